// ===== sv/lfpd_pkg.sv =====
// ----------------------------------------------------------------------------
// lfpd_pkg
// Shared types, widths, register codes and the sensor weight table of the
// line-follow PD steering block.
// ----------------------------------------------------------------------------
package lfpd_pkg;

   localparam int SENSOR_W   = 8;   // width of the sensor sample port
   localparam int GAIN_W     = 12;  // Q8 gains
   localparam int LIMIT_W    = 23;  // integral bound
   localparam int DRIVE_W    = 10;  // Q8 signed drive
   localparam int WEIGHT_W   = 12;  // signed sensor weight
   localparam int TOTAL_W    = 14;  // signed weight sum, up to sixteen sensors
   localparam int MAG_W      = 13;  // magnitude of the weight sum
   localparam int ERR_W      = 11;  // signed line position
   localparam int DIFF_W     = 12;  // signed error difference
   localparam int SUM_W      = 24;  // signed error sum
   localparam int ACC_W      = 38;  // signed PID accumulator
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 23;

   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_LIMIT = 2'd3;

   localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = 12'd384;
   localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST  = 12'd0;
   localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST  = 12'd26;
   localparam logic [LIMIT_W-1:0] INTEG_LIMIT_RST = 23'd8388607;

   // weights from the center ring outward: 0.4, 0.7, 1.2, 3.5 in Q8
   localparam logic signed [WEIGHT_W-1:0] RING_WEIGHT [4] =
      '{12'sd102, 12'sd179, 12'sd307, 12'sd896};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIV,
      ST_INTEG,
      ST_MAC,
      ST_FINISH
   } state_type;

   // weight of sensor idx out of n: lower half positive, upper half negative,
   // middle sensor of an odd count zero, outer rings beyond the fourth at 3.5
   function automatic logic signed [WEIGHT_W-1:0] weight_of(input int idx, input int n);
      int half;
      int ring;
      logic signed [WEIGHT_W-1:0] w;
      half = n >>> 1;
      ring = 0;
      w    = '0;
      if (idx < half) begin
         ring = half - 1 - idx;
         if (ring > 3) begin
            w = RING_WEIGHT[3];
         end else begin
            w = RING_WEIGHT[ring[1:0]];
         end
      end else if (idx >= n - half) begin
         ring = idx - (n - half);
         if (ring > 3) begin
            w = -RING_WEIGHT[3];
         end else begin
            w = -RING_WEIGHT[ring[1:0]];
         end
      end
      return w;
   endfunction

endpackage

// ===== sv/lfpd_div.sv =====
// ----------------------------------------------------------------------------
// lfpd_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module lfpd_div #(
   parameter int DVD_W = 13,
   parameter int DVS_W = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   rem_shift;
   logic [DVS_W+1:0] diff;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[DVD_W-1]};
      diff      = {1'b0, rem_shift} - {2'b00, dvs_ff};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_W);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // keep the trial difference when it does not go negative
         if (!diff[DVS_W+1]) begin
            rem_in = diff[DVS_W-1:0];
         end else begin
            rem_in = rem_shift[DVS_W-1:0];
         end
         quo_in = {quo_ff[DVD_W-2:0], ~diff[DVS_W+1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/line_follow_pd_steering_top.sv =====
// Path from the accepted beat to a loaded result: one sensor per cycle in the scan,
//   13 divide steps, 12 gain-bit MAC steps, and bookkeeping states.
// Line lost: the search turn skips divide and MAC.
// Beats: a new beat is taken only in idle, after the last result has loaded. A held
//   result does not block taking the next beat; that beat then waits to load.
// Reset: synchronous, active high; gains and limit load reset values, PID state and rsp_valid clear.
// ----------------------------------------------------------------------------
// line_follow_pd_steering_top
// Line follower steering: sensor position by weighted mean, PID term, and
// differential left/right drive clamped to full scale.
// ----------------------------------------------------------------------------
module line_follow_pd_steering_top #(
   parameter int SENSOR_COUNT = 8
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [lfpd_pkg::SENSOR_W-1:0]            req_sensors,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [lfpd_pkg::DRIVE_W-1:0]      rsp_left_drive,
   output logic signed [lfpd_pkg::DRIVE_W-1:0]      rsp_right_drive,
   output logic                                     rsp_line_lost,
   input  logic                                     csr_we,
   input  logic [lfpd_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [lfpd_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   localparam int IDX_W = $clog2(SENSOR_COUNT);
   localparam int CNT_W = $clog2(SENSOR_COUNT + 1);
   localparam int MB_W  = $clog2(lfpd_pkg::GAIN_W);

   localparam int TW = lfpd_pkg::TOTAL_W;
   localparam int EW = lfpd_pkg::ERR_W;
   localparam int SW = lfpd_pkg::SUM_W;
   localparam int AW = lfpd_pkg::ACC_W;
   localparam int GW = lfpd_pkg::GAIN_W;
   localparam int DW = lfpd_pkg::DRIVE_W;

   // ---------------------------------------------------------------- state
   lfpd_pkg::state_type state_ff, state_in;

   // configuration
   logic [GW-1:0]                    prop_gain_ff, integ_gain_ff, deriv_gain_ff;
   logic [lfpd_pkg::LIMIT_W-1:0]     integ_limit_ff;

   // controller memory across beats
   logic signed [EW-1:0]             prev_error_ff;
   logic signed [SW-1:0]             error_sum_ff, error_sum_in;
   logic signed [1:0]                search_dir_ff, search_dir_in;

   // per-beat working registers
   logic [SENSOR_COUNT-1:0]          sens_ff;
   logic [IDX_W-1:0]                 idx_ff;
   logic signed [TW-1:0]             total_ff, total_in;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic                             pair_lo_ff, pair_hi_ff;
   logic                             lost_ff;
   logic signed [EW-1:0]             err_ff;
   logic signed [lfpd_pkg::DIFF_W-1:0] diff_ff;
   logic signed [AW-1:0]             acc_ff, acc_in;
   logic [MB_W-1:0]                  mac_bit_ff;

   // result register
   logic                             rsp_valid_ff;
   logic signed [DW-1:0]             left_ff, right_ff, left_in, right_in;
   logic                             lost_out_ff;

   // control decodes
   logic                             scan_last;
   logic                             div_start;
   logic                             div_done;
   logic                             out_load;
   logic                             in_take;

   logic [SENSOR_COUNT-1:0]          sens_ext;
   logic [lfpd_pkg::MAG_W-1:0]       dvd_mag;
   logic [lfpd_pkg::MAG_W-1:0]       quotient;
   logic signed [lfpd_pkg::MAG_W:0]  quo_signed;
   logic signed [lfpd_pkg::MAG_W:0]  err_full;
   logic signed [SW:0]               sum_wide;
   logic signed [SW:0]               lim_wide;
   logic signed [AW-1:0]             term_p, term_i, term_d;
   logic signed [AW-1:0]             acc_biased, steer_full;
   logic signed [11:0]               steer, left_full, right_full;
   logic signed [1:0]                dir_neg;

   // sensors past the 8-bit port read as line seen
   for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_ext
      if (g < lfpd_pkg::SENSOR_W) begin : g_port
         assign sens_ext[g] = req_sensors[g];
      end else begin : g_pad
         assign sens_ext[g] = 1'b0;
      end
   end

   // ---------------------------------------------------------------- control
   assign scan_last = (state_ff == lfpd_pkg::ST_SCAN) && (idx_ff == IDX_W'(SENSOR_COUNT - 1));
   assign in_take   = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lfpd_pkg::ST_IDLE: begin
            if (req_valid) state_in = lfpd_pkg::ST_SCAN;
         end
         lfpd_pkg::ST_SCAN: begin
            if (scan_last) begin
               // no sensor on the line: straight to the search turn
               state_in = (count_in == '0) ? lfpd_pkg::ST_FINISH : lfpd_pkg::ST_DIV;
            end
         end
         lfpd_pkg::ST_DIV: begin
            if (div_done) state_in = lfpd_pkg::ST_INTEG;
         end
         lfpd_pkg::ST_INTEG: begin
            state_in = lfpd_pkg::ST_MAC;
         end
         lfpd_pkg::ST_MAC: begin
            if (mac_bit_ff == '0) state_in = lfpd_pkg::ST_FINISH;
         end
         lfpd_pkg::ST_FINISH: begin
            if (out_load) state_in = lfpd_pkg::ST_IDLE;
         end
         default: state_in = lfpd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         lfpd_pkg::ST_IDLE:   req_ready = 1'b1;
         lfpd_pkg::ST_SCAN:   div_start = scan_last && (count_in != '0);
         lfpd_pkg::ST_FINISH: out_load  = !rsp_valid_ff || rsp_ready;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // ---------------------------------------------------------------- scan
   always_comb begin
      total_in = total_ff;
      count_in = count_ff;
      if (!sens_ff[0]) begin
         total_in = total_ff + TW'(lfpd_pkg::weight_of(int'(idx_ff), SENSOR_COUNT));
         count_in = count_ff + 1'b1;
      end
   end

   assign dvd_mag = total_in[TW-1] ? lfpd_pkg::MAG_W'(-total_in)
                                   : lfpd_pkg::MAG_W'(total_in);

   lfpd_div #(
      .DVD_W (lfpd_pkg::MAG_W),
      .DVS_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dvd_mag),
      .divisor  (count_in),
      .done     (div_done),
      .quotient (quotient)
   );

   // restore the sign: quotient truncates toward zero
   assign quo_signed = {1'b0, quotient};
   assign err_full   = total_ff[TW-1] ? -quo_signed : quo_signed;

   // ---------------------------------------------------------------- integral
   always_comb begin
      sum_wide = (SW+1)'(error_sum_ff) + (SW+1)'(err_ff);
      lim_wide = (SW+1)'(integ_limit_ff);
      if (sum_wide > lim_wide) begin
         sum_wide = lim_wide;
      end else if (sum_wide < -lim_wide) begin
         sum_wide = -lim_wide;
      end
      error_sum_in = sum_wide[SW-1:0];
      // upper pair wins over lower pair
      search_dir_in = search_dir_ff;
      if (pair_lo_ff) search_dir_in = -2'sd1;
      if (pair_hi_ff) search_dir_in = 2'sd1;
   end

   // ---------------------------------------------------------------- MAC
   // MSB-first over the gain bits: acc = 2*acc + selected operands
   assign term_p = prop_gain_ff[mac_bit_ff]  ? AW'(err_ff)       : '0;
   assign term_i = integ_gain_ff[mac_bit_ff] ? AW'(error_sum_ff) : '0;
   assign term_d = deriv_gain_ff[mac_bit_ff] ? AW'(diff_ff)      : '0;
   assign acc_in = (acc_ff <<< 1) + term_p + term_i + term_d;

   // ---------------------------------------------------------------- output
   always_comb begin
      // divide by 256 toward zero, then clamp steer and drives
      acc_biased = acc_ff + (acc_ff[AW-1] ? AW'(255) : AW'(0));
      steer_full = acc_biased >>> 8;
      if (steer_full > AW'(512)) begin
         steer = 12'sd512;
      end else if (steer_full < -AW'(512)) begin
         steer = -12'sd512;
      end else begin
         steer = steer_full[11:0];
      end
      left_full  = 12'sd256 - steer;
      right_full = 12'sd256 + steer;
      if (left_full > 12'sd256)       left_full  = 12'sd256;
      else if (left_full < -12'sd256) left_full  = -12'sd256;
      if (right_full > 12'sd256)       right_full = 12'sd256;
      else if (right_full < -12'sd256) right_full = -12'sd256;

      dir_neg = -search_dir_ff;
      if (lost_ff) begin
         left_in  = {search_dir_ff, 8'd0};
         right_in = {dir_neg, 8'd0};
      end else begin
         left_in  = left_full[DW-1:0];
         right_in = right_full[DW-1:0];
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= lfpd_pkg::ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         prop_gain_ff   <= lfpd_pkg::PROP_GAIN_RST;
         integ_gain_ff  <= lfpd_pkg::INTEG_GAIN_RST;
         deriv_gain_ff  <= lfpd_pkg::DERIV_GAIN_RST;
         integ_limit_ff <= lfpd_pkg::INTEG_LIMIT_RST;
         prev_error_ff  <= '0;
         error_sum_ff   <= '0;
         search_dir_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_index)
               lfpd_pkg::CSR_PROP_GAIN:   prop_gain_ff   <= csr_wdata[GW-1:0];
               lfpd_pkg::CSR_INTEG_GAIN:  integ_gain_ff  <= csr_wdata[GW-1:0];
               lfpd_pkg::CSR_DERIV_GAIN:  deriv_gain_ff  <= csr_wdata[GW-1:0];
               lfpd_pkg::CSR_INTEG_LIMIT: integ_limit_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         // commit controller memory once per seen-line beat
         if (state_ff == lfpd_pkg::ST_INTEG) begin
            prev_error_ff <= err_ff;
            error_sum_ff  <= error_sum_in;
            search_dir_ff <= search_dir_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         sens_ff    <= sens_ext;
         idx_ff     <= '0;
         total_ff   <= '0;
         count_ff   <= '0;
         pair_lo_ff <= !sens_ext[0] && !sens_ext[1];
         pair_hi_ff <= !sens_ext[SENSOR_COUNT-2] && !sens_ext[SENSOR_COUNT-1];
         lost_ff    <= 1'b0;
      end else if (state_ff == lfpd_pkg::ST_SCAN) begin
         // advance one sensor per cycle
         sens_ff  <= sens_ff >> 1;
         idx_ff   <= idx_ff + 1'b1;
         total_ff <= total_in;
         count_ff <= count_in;
         lost_ff  <= (count_in == '0);
      end
      if (div_done) begin
         err_ff <= err_full[EW-1:0];
      end
      if (state_ff == lfpd_pkg::ST_INTEG) begin
         diff_ff    <= (lfpd_pkg::DIFF_W)'(err_ff) - (lfpd_pkg::DIFF_W)'(prev_error_ff);
         acc_ff     <= '0;
         mac_bit_ff <= MB_W'(GW - 1);
      end else if (state_ff == lfpd_pkg::ST_MAC) begin
         acc_ff     <= acc_in;
         mac_bit_ff <= mac_bit_ff - 1'b1;
      end
      if (out_load) begin
         left_ff     <= left_in;
         right_ff    <= right_in;
         lost_out_ff <= lost_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_drive  = left_ff;
   assign rsp_right_drive = right_ff;
   assign rsp_line_lost   = lost_out_ff;

   // ---------------------------------------------------------------- checks
`ifndef ASSERT_OFF
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff)
      else $error("loaded result not presented");

   a_take_scans: assert property (@(posedge clock) disable iff (reset)
      in_take |=> state_ff == lfpd_pkg::ST_SCAN)
      else $error("accepted beat did not start a scan");

   a_lost_mirror: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && lost_out_ff |-> left_ff == -right_ff)
      else $error("search turn drives not opposite");

   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (left_ff >= -10'sd256) && (left_ff <= 10'sd256)
                    && (right_ff >= -10'sd256) && (right_ff <= 10'sd256))
      else $error("drive beyond full scale");
`endif

endmodule
